FILE: hw/rtl/brthm_pkg.sv
`timescale 1ns / 1ps

package brthm_pkg;

    // Default geometry
    localparam int ROWS_DEF            = 4;
    localparam int SENSORS_PER_ROW_DEF = 4;

    // Field widths
    localparam int TEMP_W  = 12;
    localparam int TIME_W  = 32;
    localparam int TOUT_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic signed [TEMP_W-1:0] HIGH_THRESHOLD_RST = 12'sd720;
    localparam logic signed [TEMP_W-1:0] LOW_THRESHOLD_RST  = 12'sd640;
    localparam logic [TOUT_W-1:0]        DEAD_TIMEOUT_RST   = 16'd10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_THRESHOLD = 2'd0,
        REG_LOW_THRESHOLD  = 2'd1,
        REG_DEAD_TIMEOUT   = 2'd2
    } cfg_reg_t;

    // Input operations
    typedef enum logic {
        OP_REPORT = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // Row conditions
    typedef enum logic [1:0] {
        COND_NORMAL     = 2'd0,
        COND_OVERHEATED = 2'd1,
        COND_DEAD       = 2'd2
    } cond_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    typedef struct packed {
        op_t                      opcode;
        logic [SLOT_W-1:0]        sensor_slot;
        logic                     reading_valid;
        logic signed [TEMP_W-1:0] temperature;
    } in_item_t;

    typedef struct packed {
        logic [1:0] row_number;
        logic [1:0] row_condition;
        logic       row_enable;
        logic       last_in_run;
    } out_item_t;

    // One sensor memory entry
    typedef struct packed {
        logic [TIME_W-1:0]        last_seen;
        logic signed [TEMP_W-1:0] temp;
        logic                     present;
    } sens_entry_t;

endpackage

FILE: hw/rtl/battery_row_thermal_health_monitor.sv
`timescale 1ns / 1ps

// Channel   Ports                                Direction  Contents
// s_        s_valid, s_ready, s_data             in         in_item_t (report or tick)
// m_        m_valid, m_ready, m_data             out        out_item_t (one per row)
// cfg_      cfg_valid, cfg_ready, cfg_index/data in         register writes
//
// A sensor report writes the sensor memory in the cycle of the transfer.
// A tick starts a scan that reads the sensors through the single read port of the sensor memory,
// one sensor per cycle, and closes each row with a verdict state (ST_DONE).
// Reset clears time, row states and the per-entry valid bits; an entry never written reads as zero.
// A full output register stalls the scan at the end of a row; after the last row the block
// takes new transfers while that result still waits. The config port is always ready.
module battery_row_thermal_health_monitor
    import brthm_pkg::*;
#(
    parameter int ROWS            = ROWS_DEF,
    parameter int SENSORS_PER_ROW = SENSORS_PER_ROW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SENSOR_COUNT = ROWS * SENSORS_PER_ROW;
    localparam int AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KW = (SENSORS_PER_ROW > 1) ? $clog2(SENSORS_PER_ROW) : 1;

    // Configuration registers
    logic signed [TEMP_W-1:0] high_thr_reg;
    logic signed [TEMP_W-1:0] low_thr_reg;
    logic [TOUT_W-1:0]        timeout_reg;

    // Control state
    state_t            state_reg, state_next;
    logic [TIME_W-1:0] time_now_reg, time_now_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [AW-1:0]     sens_reg, sens_next;
    logic              pend_reg, pend_next;
    logic              acc_dead_reg, acc_dead_next;
    logic              acc_hi_reg, acc_hi_next;
    logic              acc_lo_reg, acc_lo_next;
    cond_t             row_state_reg [ROWS];
    logic [SENSOR_COUNT-1:0] ent_valid_reg;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    // Sensor memory
    sens_entry_t sens_mem [SENSOR_COUNT];
    sens_entry_t rd_data_reg;
    logic        rd_ok_reg;
    sens_entry_t rd_ent;

    // Strobes
    logic        in_xfer;
    logic        tick_xfer;
    logic        mem_we;
    logic        rd_en;
    logic        out_load;
    logic        out_free;
    logic        row_last_k;
    logic        last_row;
    logic [8:0]  slot_ext;
    logic [AW+SLOT_W-1:0] slot_wide;
    logic [AW-1:0] wr_addr;
    sens_entry_t wr_ent;
    logic [TIME_W-1:0] age;
    logic        s_dead, s_hi, s_lo;
    logic        fin_dead, fin_hi, fin_lo;
    cond_t       st_base, st_new;
    logic [RW+1:0] row_ext;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_thr_reg <= HIGH_THRESHOLD_RST;
            low_thr_reg  <= LOW_THRESHOLD_RST;
            timeout_reg  <= DEAD_TIMEOUT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data[TEMP_W-1:0];
                REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data[TEMP_W-1:0];
                REG_DEAD_TIMEOUT:   timeout_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Decode the input transfer
    assign in_xfer   = s_valid && s_ready;
    assign tick_xfer = in_xfer && (s_data.opcode == OP_TICK);
    assign slot_ext  = {5'b0, s_data.sensor_slot};
    assign slot_wide = {{AW{1'b0}}, s_data.sensor_slot};
    assign wr_addr   = slot_wide[AW-1:0];
    assign mem_we    = in_xfer && (s_data.opcode == OP_REPORT)
                       && (slot_ext < 9'(SENSOR_COUNT));

    // Build the entry written by a report
    always_comb begin
        if (s_data.reading_valid) begin
            wr_ent.last_seen = time_now_reg;
            wr_ent.temp      = s_data.temperature;
            wr_ent.present   = 1'b1;
        end else begin
            wr_ent.last_seen = time_now_reg - {15'b0, timeout_reg, 1'b0};
            wr_ent.temp      = '0;
            wr_ent.present   = 1'b0;
        end
    end

    // Sensor memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sens_mem[wr_addr] <= wr_ent;
        end
        if (rd_en) begin
            rd_data_reg <= sens_mem[sens_reg];
        end
    end

    // Track written entries; an unwritten entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end else begin
            if (mem_we) begin
                ent_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_ok_reg <= ent_valid_reg[sens_reg];
            end
        end
    end

    assign rd_ent = rd_ok_reg ? rd_data_reg : '0;

    // Judge the sensor on the read port
    assign age    = time_now_reg - rd_ent.last_seen;
    assign s_dead = age > {16'b0, timeout_reg};
    assign s_hi   = rd_ent.present && (rd_ent.temp > high_thr_reg);
    assign s_lo   = rd_ent.present && (rd_ent.temp > low_thr_reg);

    // Fold in the last sensor of the row
    assign fin_dead = acc_dead_reg || s_dead;
    assign fin_hi   = acc_hi_reg || s_hi;
    assign fin_lo   = acc_lo_reg || s_lo;

    // Row verdict with hysteresis; a dead row restarts as normal
    always_comb begin
        st_base = (row_state_reg[row_reg] == COND_DEAD) ? COND_NORMAL : row_state_reg[row_reg];
        if (fin_dead) begin
            st_new = COND_DEAD;
        end else if (st_base == COND_NORMAL) begin
            st_new = fin_hi ? COND_OVERHEATED : COND_NORMAL;
        end else begin
            st_new = fin_lo ? COND_OVERHEATED : COND_NORMAL;
        end
    end

    assign row_last_k = (k_reg == KW'(SENSORS_PER_ROW - 1));
    assign last_row   = (row_reg == RW'(ROWS - 1));
    assign out_free   = !m_valid_reg || m_ready;
    assign row_ext    = {2'b0, row_reg};

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (tick_xfer) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (row_last_k) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = last_row ? ST_IDLE : ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready  = 1'b1;
            ST_SCAN: rd_en    = 1'b1;
            ST_DONE: out_load = out_free;
            default: ;
        endcase
    end

    // Counters, accumulators and output register
    always_comb begin
        time_now_next = time_now_reg;
        row_next      = row_reg;
        k_next        = k_reg;
        sens_next     = sens_reg;
        pend_next     = pend_reg;
        acc_dead_next = acc_dead_reg;
        acc_hi_next   = acc_hi_reg;
        acc_lo_next   = acc_lo_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (tick_xfer) begin
            time_now_next = time_now_reg + 32'd1;
            row_next      = '0;
            k_next        = '0;
            sens_next     = '0;
            pend_next     = 1'b0;
            acc_dead_next = 1'b0;
            acc_hi_next   = 1'b0;
            acc_lo_next   = 1'b0;
        end

        if (rd_en) begin
            pend_next = 1'b1;
            k_next    = row_last_k ? k_reg : k_reg + KW'(1);
            sens_next = sens_reg + AW'(1);
            if (pend_reg) begin
                acc_dead_next = fin_dead;
                acc_hi_next   = fin_hi;
                acc_lo_next   = fin_lo;
            end
        end

        if (out_load) begin
            m_valid_next              = 1'b1;
            m_data_next.row_number    = row_ext[1:0];
            m_data_next.row_condition = st_new;
            m_data_next.row_enable    = (st_new == COND_NORMAL);
            m_data_next.last_in_run   = last_row;
            row_next      = last_row ? row_reg : row_reg + RW'(1);
            k_next        = '0;
            pend_next     = 1'b0;
            acc_dead_next = 1'b0;
            acc_hi_next   = 1'b0;
            acc_lo_next   = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            time_now_reg <= '0;
            row_reg      <= '0;
            k_reg        <= '0;
            sens_reg     <= '0;
            pend_reg     <= 1'b0;
            acc_dead_reg <= 1'b0;
            acc_hi_reg   <= 1'b0;
            acc_lo_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            time_now_reg <= time_now_next;
            row_reg      <= row_next;
            k_reg        <= k_next;
            sens_reg     <= sens_next;
            pend_reg     <= pend_next;
            acc_dead_reg <= acc_dead_next;
            acc_hi_reg   <= acc_hi_next;
            acc_lo_reg   <= acc_lo_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // Row state store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                row_state_reg[r] <= COND_NORMAL;
            end
        end else if (out_load) begin
            row_state_reg[row_reg] <= st_new;
        end
    end

    // Reports never land while a scan reads the memory
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_IDLE))
        else $error("sensor memory written during a scan");

    // A tick starts a scan at the first sensor
    assert property (@(posedge aclk) disable iff (!aresetn)
        tick_xfer |=> (state_reg == ST_SCAN) && (sens_reg == '0) && (row_reg == '0))
        else $error("tick did not start the scan at sensor zero");

    // A tick advances time by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        tick_xfer |=> (time_now_reg == $past(time_now_reg) + 32'd1))
        else $error("time did not advance on tick");

    // The result for the last row ends the scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_row) |=> (state_reg == ST_IDLE) && m_valid_reg
                                   && m_data_reg.last_in_run)
        else $error("scan did not end after the last row");

endmodule

FILE: tb/row_health_checker.sv
`timescale 1ns / 1ps

module row_health_checker
    import brthm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    verdicts_due
);

    localparam int N_ROWS  = ROWS_DEF;
    localparam int PER_ROW = SENSORS_PER_ROW_DEF;
    localparam int N_SENS  = N_ROWS * PER_ROW;

    // Shadow copy of the register file
    logic signed [TEMP_W-1:0] hot_limit;
    logic signed [TEMP_W-1:0] cool_limit;
    logic [TOUT_W-1:0]        stale_limit;

    // Shadow copy of the sensor table and row states
    logic [TIME_W-1:0]        now_ticks;
    logic [TIME_W-1:0]        seen_at [N_SENS];
    logic signed [TEMP_W-1:0] reading [N_SENS];
    logic                     has_reading [N_SENS];
    cond_t                    row_cond [N_ROWS];

    out_item_t verdict_q [$];
    int        errors;

    // Advance time by one tick and queue the verdict of every row
    task automatic advance_and_judge();
        logic [TIME_W-1:0] age;
        logic              stale;
        logic              hot;
        logic              warm;
        cond_t             st;
        out_item_t         v;
        int                s;
        now_ticks = now_ticks + TIME_W'(1);
        for (int r = 0; r < N_ROWS; r++) begin
            // A dead row starts over as normal before it is judged again
            st = (row_cond[r] == COND_DEAD) ? COND_NORMAL : row_cond[r];
            stale = 1'b0;
            hot = 1'b0;
            warm = 1'b0;
            for (int k = 0; k < PER_ROW; k++) begin
                s = r * PER_ROW + k;
                age = now_ticks - seen_at[s];
                if (age > TIME_W'(stale_limit))
                    stale = 1'b1;
                if (has_reading[s] && reading[s] > hot_limit)
                    hot = 1'b1;
                if (has_reading[s] && reading[s] > cool_limit)
                    warm = 1'b1;
            end
            // Dead wins over the hysteresis rule
            if (stale) begin
                st = COND_DEAD;
            end else if (st == COND_NORMAL) begin
                if (hot)
                    st = COND_OVERHEATED;
            end else begin
                st = warm ? COND_OVERHEATED : COND_NORMAL;
            end
            row_cond[r] = st;
            v.row_number    = 2'(r);
            v.row_condition = st;
            v.row_enable    = (st == COND_NORMAL);
            v.last_in_run   = (r == N_ROWS - 1);
            verdict_q.push_back(v);
        end
    endtask

    task automatic flag_result(input string what, input out_item_t want, input out_item_t got);
        if (errors < 10)
            $display({"%0t: %s: expected row %0d cond %0d en %0b last %0b, ",
                      "got row %0d cond %0d en %0b last %0b"},
                     $time, what, want.row_number, want.row_condition, want.row_enable,
                     want.last_in_run, got.row_number, got.row_condition, got.row_enable,
                     got.last_in_run);
        errors = errors + 1;
    endtask

    always @(posedge aclk) begin
        int        s;
        out_item_t want;
        if (!aresetn) begin
            hot_limit   = HIGH_THRESHOLD_RST;
            cool_limit  = LOW_THRESHOLD_RST;
            stale_limit = DEAD_TIMEOUT_RST;
            now_ticks   = '0;
            for (int i = 0; i < N_SENS; i++) begin
                seen_at[i]     = '0;
                reading[i]     = '0;
                has_reading[i] = 1'b0;
            end
            for (int i = 0; i < N_ROWS; i++)
                row_cond[i] = COND_NORMAL;
            verdict_q.delete();
            errors = 0;
        end else begin
            // Check the result transfer against the oldest pending verdict
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    want = '0;
                    flag_result("unexpected result", want, m_data);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_data.row_number !== want.row_number ||
                        m_data.row_condition !== want.row_condition ||
                        m_data.row_enable !== want.row_enable ||
                        m_data.last_in_run !== want.last_in_run)
                        flag_result("result mismatch", want, m_data);
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_HIGH_THRESHOLD: hot_limit   = cfg_data[TEMP_W-1:0];
                    REG_LOW_THRESHOLD:  cool_limit  = cfg_data[TEMP_W-1:0];
                    REG_DEAD_TIMEOUT:   stale_limit = cfg_data[TOUT_W-1:0];
                    default: ;
                endcase
            end

            // Apply the accepted input transfer
            if (s_valid && s_ready) begin
                if (s_data.opcode == OP_TICK) begin
                    advance_and_judge();
                end else begin
                    s = int'(s_data.sensor_slot);
                    if (s < N_SENS) begin
                        if (s_data.reading_valid) begin
                            seen_at[s]     = now_ticks;
                            reading[s]     = s_data.temperature;
                            has_reading[s] = 1'b1;
                        end else begin
                            // Backdate a failed sensor so its row dies at the next tick
                            seen_at[s]     = now_ticks - (TIME_W'(stale_limit) << 1);
                            reading[s]     = '0;
                            has_reading[s] = 1'b0;
                        end
                    end
                end
            end
        end
        mismatches   <= errors;
        verdicts_due <= verdict_q.size();
    end

endmodule

FILE: tb/battery_row_thermal_health_monitor_test.sv
`timescale 1ns / 1ps

module battery_row_thermal_health_monitor_test;
    import brthm_pkg::*;

    localparam int N_SENS        = ROWS_DEF * SENSORS_PER_ROW_DEF;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    in_item_t              s_data    = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_ready;
    logic                  m_valid;
    out_item_t             m_data;
    logic                  cfg_ready;

    int mismatches;
    int verdicts_due;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    logic hold_go = 1'b0;
    logic hold_on = 1'b0;

    // Thresholds currently programmed, used to aim temperatures
    logic signed [TEMP_W-1:0] cur_hi = HIGH_THRESHOLD_RST;
    logic signed [TEMP_W-1:0] cur_lo = LOW_THRESHOLD_RST;

    battery_row_thermal_health_monitor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    row_health_checker check_rows (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .verdicts_due (verdicts_due)
    );

    always #2 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold while hold_on is set
    always @(posedge aclk) begin
        if (!aresetn || hold_on)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Hold off the receiver once, long enough for the block to back up
    initial begin : receiver_hold
        wait (hold_go);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    // Offer one item, with random idle cycles first, and hold it until the transfer
    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent = items_sent + 1;
    endtask

    task automatic report_sensor(input int slot, input logic ok,
                                 input logic signed [TEMP_W-1:0] t);
        in_item_t it;
        it.opcode        = OP_REPORT;
        it.sensor_slot   = SLOT_W'(slot);
        it.reading_valid = ok;
        it.temperature   = t;
        send_item(it);
    endtask

    // Tick with random filler in the unused fields
    task automatic tick();
        logic [31:0] raw;
        in_item_t    it;
        raw = $urandom;
        it = raw[$bits(in_item_t)-1:0];
        it.opcode = OP_TICK;
        send_item(it);
    endtask

    task automatic send_noise();
        logic [31:0] raw;
        raw = $urandom;
        send_item(raw[$bits(in_item_t)-1:0]);
    endtask

    // Stop offering and wait until every pending verdict has arrived
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due != 0) @(posedge aclk);
    endtask

    // Program all registers once the block has gone quiet
    task automatic configure(input logic signed [TEMP_W-1:0] hi,
                             input logic signed [TEMP_W-1:0] lo,
                             input logic [TOUT_W-1:0] tout);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_HIGH_THRESHOLD;
        cfg_data  <= {{(CFG_DATA_W - TEMP_W){hi[TEMP_W-1]}}, hi};
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_LOW_THRESHOLD;
        cfg_data  <= {{(CFG_DATA_W - TEMP_W){lo[TEMP_W-1]}}, lo};
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_DEAD_TIMEOUT;
        cfg_data  <= tout;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_hi = hi;
        cur_lo = lo;
    endtask

    // Mostly temperatures close to the thresholds, some anywhere in range
    function automatic logic signed [TEMP_W-1:0] pick_temp();
        int t;
        case ($urandom_range(0, 4))
            0, 1:    t = int'(cur_hi) + int'($urandom_range(0, 6)) - 3;
            2:       t = int'(cur_lo) + int'($urandom_range(0, 6)) - 3;
            3:       t = int'($urandom_range(0, 4095)) - 2048;
            default: t = int'($urandom_range(0, 800)) - 200;
        endcase
        return t[TEMP_W-1:0];
    endfunction

    // Mostly report rounds followed by a tick, plus noise and bare ticks
    task automatic run_random(input int quota);
        int goal;
        int pick;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                for (int k = 0; k < N_SENS; k++)
                    if ($urandom_range(0, 9) < 7)
                        report_sensor(k, ($urandom_range(0, 24) != 0), pick_temp());
                if ($urandom_range(0, 7) == 0)
                    drain();
                tick();
            end else if (pick < 9) begin
                repeat ($urandom_range(1, 4)) send_noise();
            end else begin
                repeat ($urandom_range(1, 2)) tick();
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, no idling: directed checks first
        tick();
        report_sensor(0, 1'b1, 12'sh7FF);
        report_sensor(5, 1'b1, -12'sd2048);
        report_sensor(15, 1'b1, 12'sd721);
        report_sensor(10, 1'b0, -12'sd1);
        report_sensor(4, 1'b1, 12'sd720);
        tick();
        // Overheated rows: one stays above the low mark, one drops to it
        report_sensor(0, 1'b1, 12'sd641);
        report_sensor(15, 1'b1, 12'sd640);
        report_sensor(10, 1'b1, 12'sd0);
        tick();
        report_sensor(0, 1'b1, 12'sd640);
        report_sensor(12, 1'b1, 12'sd700);
        tick();
        // Dead overrides a hot sensor, then recovery restarts from normal
        report_sensor(0, 1'b1, 12'sh7FF);
        report_sensor(1, 1'b0, 12'sd0);
        tick();
        report_sensor(1, 1'b1, 12'sd100);
        tick();
        report_sensor(1, 1'b1, -12'sd2048);
        tick();
        run_random(50);

        // Widest thresholds and longest timeout, sender idling
        configure(12'sh7FF, -12'sd2048, 16'hFFFF);
        send_idle_pct  = 74;
        recv_stall_pct = 0;
        run_random(70);

        // Inverted thresholds and a timeout of one tick, receiver stalling
        configure(-12'sd2048, 12'sh7FF, 16'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 74;
        run_random(70);

        configure(12'sd800, 12'sd600, 16'd3);
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        run_random(70);

        // Zero timeout: every row dies at every tick
        configure(12'sd720, 12'sd640, 16'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(30);

        // Long receiver hold while items keep coming
        configure(12'sd1000, 12'sd200, 16'd20);
        hold_go = 1'b1;
        run_random(60);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && verdicts_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
